[src/tcf_pkg.sv]
// Shared types, constants and arithmetic helpers for the tilt complementary filter.
// Used by tcf_front, tcf_fifo, tcf_back and tilt_complementary_filter; no dependencies.
package tcf_pkg;

   localparam int TABLE_LEN = 24;   // entries in the arctangent table
   localparam int ACC_W     = 34;   // CORDIC angle accumulator, Q24 degrees
   localparam int ANG_W     = 29;   // accelerometer angle, room for 180 deg at 20 frac bits
   localparam int OUT_W     = 26;   // result fields and kept angle
   localparam int XY_W      = 27;   // CORDIC vector components

   localparam logic [16:0] ALPHA_RESET  = 17'd64225;
   localparam logic [23:0] GYRO_RESET   = 24'd128070;
   localparam logic [15:0] PERIOD_RESET = 16'd655;
   localparam logic [16:0] ALPHA_ONE    = 17'd65536;

   typedef enum logic [1:0] {
      CSR_ALPHA  = 2'd0,
      CSR_GYRO   = 2'd1,
      CSR_PERIOD = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_CORD = 3'b010,
      F_FIN  = 3'b100
   } front_state_type;

   typedef enum logic [3:0] {
      B_IDLE = 4'b0001,
      B_ADD  = 4'b0010,
      B_MUL  = 4'b0100,
      B_FIN  = 4'b1000
   } back_state_type;

   // One classified sample handed from front to back.
   typedef struct packed {
      logic signed [ANG_W-1:0] tilt_ref;
      logic signed [OUT_W-1:0] rate;
   } pair_type;

   // atan(2^-i) in Q24 degrees
   function automatic logic [31:0] atan_q24(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:  v = 32'd754974720;
         5'd1:  v = 32'd445687602;
         5'd2:  v = 32'd235489088;
         5'd3:  v = 32'd119537938;
         5'd4:  v = 32'd60000934;
         5'd5:  v = 32'd30029717;
         5'd6:  v = 32'd15018523;
         5'd7:  v = 32'd7509720;
         5'd8:  v = 32'd3754917;
         5'd9:  v = 32'd1877466;
         5'd10: v = 32'd938734;
         5'd11: v = 32'd469367;
         5'd12: v = 32'd234684;
         5'd13: v = 32'd117342;
         5'd14: v = 32'd58671;
         5'd15: v = 32'd29335;
         5'd16: v = 32'd14668;
         5'd17: v = 32'd7334;
         5'd18: v = 32'd3667;
         5'd19: v = 32'd1833;
         5'd20: v = 32'd917;
         5'd21: v = 32'd458;
         5'd22: v = 32'd229;
         5'd23: v = 32'd115;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

   // Round v / 2^s to nearest, halves away from zero (s constant, s >= 1).
   function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v, input int s);
      logic signed [63:0] t;
      t = v + (64'sd1 <<< (s - 1));
      if (v[63]) begin
         t = t - 64'sd1;
      end
      return t >>> s;
   endfunction

   // Saturate to +-512 degrees in Q(frac), never beyond the 26-bit range.
   function automatic logic signed [OUT_W-1:0] sat_q(input logic signed [63:0] v,
                                                     input int frac);
      logic signed [63:0] lp;
      logic signed [63:0] ln;
      lp = (64'sd512 <<< frac) - 64'sd1;
      ln = -(64'sd512 <<< frac);
      if (lp > 64'sd33554431) begin
         lp = 64'sd33554431;
      end
      if (ln < -64'sd33554432) begin
         ln = -64'sd33554432;
      end
      if (v > lp) begin
         return lp[OUT_W-1:0];
      end else if (v < ln) begin
         return ln[OUT_W-1:0];
      end
      return v[OUT_W-1:0];
   endfunction

endpackage

[src/tcf_front.sv]
// Front end: accepts IMU samples, runs the iterative CORDIC arctangent and gyro scaling.
// Depends on tcf_pkg.
module tcf_front #(
   parameter int CORDIC_STAGES = 16,
   parameter int FRAC_BITS     = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic signed [15:0]    accel_y,
   input  logic signed [15:0]    accel_z,
   input  logic signed [15:0]    gyro_x,
   input  logic [23:0]           gyro_gain,
   output logic                  push_valid,
   input  logic                  push_ready,
   output tcf_pkg::pair_type     push_data
);

   localparam int NSTG = (CORDIC_STAGES < tcf_pkg::TABLE_LEN) ? CORDIC_STAGES
                                                              : tcf_pkg::TABLE_LEN;
   localparam int CW   = (NSTG > 1) ? $clog2(NSTG) : 1;
   localparam int SHR  = 24 - FRAC_BITS;
   localparam int XW   = tcf_pkg::XY_W;
   localparam int AW   = tcf_pkg::ACC_W;

   tcf_pkg::front_state_type state_ff, state_in;
   logic signed [XW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic                 zero_ff, zero_in;
   logic signed [40:0]   prod_ff, prod_in;
   logic [CW-1:0]        cnt_ff, cnt_in;

   logic signed [XW-1:0] xs, ys, x0, y0, dx, dy;
   logic signed [AW-1:0] a0, tab;
   logic signed [63:0]   acc_rnd, lim180, ang;
   logic                 accept;

   assign req_ready  = (state_ff == tcf_pkg::F_IDLE);
   assign accept     = req_valid && req_ready;
   assign push_valid = (state_ff == tcf_pkg::F_FIN);

   // Pre-rotate left half-plane vectors by +-90 degrees.
   always_comb begin
      xs = {{3{accel_z[15]}}, accel_z, 8'b0};
      ys = {{3{accel_y[15]}}, accel_y, 8'b0};
      x0 = xs;
      y0 = ys;
      a0 = '0;
      if (xs[XW-1]) begin
         if (!ys[XW-1]) begin
            x0 = ys;
            y0 = -xs;
            a0 = AW'(64'sd90 <<< 24);
         end else begin
            x0 = -ys;
            y0 = xs;
            a0 = AW'(-(64'sd90 <<< 24));
         end
      end
   end

   assign dx  = y_ff >>> cnt_ff;
   assign dy  = x_ff >>> cnt_ff;
   assign tab = {2'b00, tcf_pkg::atan_q24(5'(cnt_ff))};

   // Round accumulator to Q(F) and clamp to +-180 degrees.
   always_comb begin
      acc_rnd = tcf_pkg::rnd_shr(64'(acc_ff), SHR);
      lim180  = 64'sd180 <<< FRAC_BITS;
      ang     = acc_rnd;
      if (acc_rnd > lim180) begin
         ang = lim180;
      end else if (acc_rnd < -lim180) begin
         ang = -lim180;
      end
      if (zero_ff) begin
         ang = '0;
      end
      push_data.tilt_ref = ang[tcf_pkg::ANG_W-1:0];
      push_data.rate = tcf_pkg::sat_q(tcf_pkg::rnd_shr(64'(prod_ff), SHR), FRAC_BITS);
   end

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      acc_in   = acc_ff;
      zero_in  = zero_ff;
      prod_in  = prod_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         tcf_pkg::F_IDLE: begin
            if (accept) begin
               x_in     = x0;
               y_in     = y0;
               acc_in   = a0;
               zero_in  = (accel_y == 16'sd0) && (accel_z == 16'sd0);
               prod_in  = $signed(gyro_x) * $signed({1'b0, gyro_gain});
               cnt_in   = '0;
               state_in = tcf_pkg::F_CORD;
            end
         end
         tcf_pkg::F_CORD: begin
            // one micro-rotation per cycle
            if (!y_ff[XW-1]) begin
               x_in   = x_ff + dx;
               y_in   = y_ff - dy;
               acc_in = acc_ff + tab;
            end else begin
               x_in   = x_ff - dx;
               y_in   = y_ff + dy;
               acc_in = acc_ff - tab;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(NSTG - 1)) begin
               state_in = tcf_pkg::F_FIN;
            end
         end
         tcf_pkg::F_FIN: begin
            if (push_ready) begin
               state_in = tcf_pkg::F_IDLE;
            end
         end
         default: state_in = tcf_pkg::F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tcf_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      acc_ff  <= acc_in;
      zero_ff <= zero_in;
      prod_ff <= prod_in;
      cnt_ff  <= cnt_in;
   end

endmodule

[src/tcf_fifo.sv]
// Two-entry queue that decouples the front end from the back end.
// Depends on tcf_pkg.
module tcf_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  tcf_pkg::pair_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output tcf_pkg::pair_type pop_data
);

   tcf_pkg::pair_type mem [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_data   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[src/tcf_back.sv]
// Back end: gyro integration, complementary blend, kept angle and result register.
// Depends on tcf_pkg.
module tcf_back #(
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  tcf_pkg::pair_type     pop_data,
   input  logic [16:0]           alpha,
   input  logic [15:0]           period,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic signed [25:0]    tilt_angle,
   output logic signed [25:0]    tilt_rate
);

   localparam int OW = tcf_pkg::OUT_W;
   localparam int GW = tcf_pkg::ANG_W;

   tcf_pkg::back_state_type state_ff, state_in;
   logic signed [OW-1:0] angle_ff, angle_in;
   logic signed [OW-1:0] rate_ff, rate_in;
   logic signed [GW-1:0] accel_ff, accel_in;
   logic signed [42:0]   prod1_ff, prod1_in;
   logic signed [31:0]   diff_ff, diff_in;
   logic signed [49:0]   prod2_ff, prod2_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [OW-1:0] out_angle_ff, out_angle_in, out_rate_ff, out_rate_in;

   logic [16:0]          alpha_c;
   logic signed [63:0]   diff_w, mix;
   logic signed [OW-1:0] new_angle;
   logic                 out_free, fire;

   assign alpha_c    = alpha[16] ? tcf_pkg::ALPHA_ONE : alpha;
   assign pop_ready  = (state_ff == tcf_pkg::B_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign fire       = (state_ff == tcf_pkg::B_FIN) && out_free;
   assign rsp_valid  = rsp_valid_ff;
   assign tilt_angle = out_angle_ff;
   assign tilt_rate  = out_rate_ff;

   // pred - accel; the blend is alpha*(pred - accel) + accel<<16
   assign diff_w = 64'(angle_ff) + tcf_pkg::rnd_shr(64'(prod1_ff), 16) - 64'(accel_ff);
   assign mix    = 64'(prod2_ff) + (64'(accel_ff) <<< 16);
   assign new_angle = tcf_pkg::sat_q(tcf_pkg::rnd_shr(mix, 16), FRAC_BITS);

   always_comb begin
      state_in     = state_ff;
      angle_in     = angle_ff;
      rate_in      = rate_ff;
      accel_in     = accel_ff;
      prod1_in     = prod1_ff;
      diff_in      = diff_ff;
      prod2_in     = prod2_ff;
      out_angle_in = out_angle_ff;
      out_rate_in  = out_rate_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         tcf_pkg::B_IDLE: begin
            if (pop_valid) begin
               rate_in  = pop_data.rate;
               accel_in = pop_data.tilt_ref;
               prod1_in = $signed(pop_data.rate) * $signed({1'b0, period});
               state_in = tcf_pkg::B_ADD;
            end
         end
         tcf_pkg::B_ADD: begin
            diff_in  = diff_w[31:0];
            state_in = tcf_pkg::B_MUL;
         end
         tcf_pkg::B_MUL: begin
            prod2_in = diff_ff * $signed({1'b0, alpha_c});
            state_in = tcf_pkg::B_FIN;
         end
         tcf_pkg::B_FIN: begin
            if (fire) begin
               angle_in     = new_angle;
               out_angle_in = new_angle;
               out_rate_in  = rate_ff;
               rsp_valid_in = 1'b1;
               state_in     = tcf_pkg::B_IDLE;
            end
         end
         default: state_in = tcf_pkg::B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcf_pkg::B_IDLE;
         angle_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         angle_ff     <= angle_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rate_ff      <= rate_in;
      accel_ff     <= accel_in;
      prod1_ff     <= prod1_in;
      diff_ff      <= diff_in;
      prod2_ff     <= prod2_in;
      out_angle_ff <= out_angle_in;
      out_rate_ff  <= out_rate_in;
   end

endmodule

[src/tilt_complementary_filter.sv]
// Top level of the tilt complementary filter: configuration registers and stream ports.
// Depends on tcf_pkg, tcf_front, tcf_fifo and tcf_back.
//
// Usage:
//   req_* carries one IMU sample per item (accel Y, accel Z, gyro X, raw counts).
//   rsp_* returns one item per sample: the filtered tilt angle and the gyro rate,
//   both signed Q(FRAC_BITS) degrees, saturated to +-512 degrees.
//   csr_* writes alpha (index 0), gyro scale (index 1) and sample period (index 2);
//   write them only while no sample is in flight.
// Timing:
//   The front end holds one sample at a time: it loads the sample, then runs one
//   arctangent micro-rotation per cycle for each of min(CORDIC_STAGES, 24) stages,
//   then rounds and offers the result until the queue takes it. That single CORDIC
//   datapath takes no new sample before the last one has been pushed to the queue.
//   The back end works on one item at a time in four steps (integrate, blend, multiply,
//   round) and waits in the last step while the result register is held.
// Reset clears the kept angle to zero and loads the register defaults.
// A stalled receiver holds the result register; a two-entry queue between the front and
// back holds up to two finished samples; once it is full the front end holds its own.
module tilt_complementary_filter #(
   parameter int CORDIC_STAGES = 16,
   parameter int FRAC_BITS     = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // accel_y[15:0], accel_z[31:16], gyro_x[47:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // tilt_angle[25:0], tilt_rate[51:26], zero pad
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   logic [16:0] alpha_ff, alpha_in;
   logic [23:0] gyro_ff, gyro_in;
   logic [15:0] period_ff, period_in;

   logic              push_valid, push_ready, pop_valid, pop_ready;
   tcf_pkg::pair_type push_data, pop_data;
   logic signed [25:0] tilt_angle, tilt_rate;

   // Decode register writes; an unused index is dropped.
   always_comb begin
      alpha_in  = alpha_ff;
      gyro_in   = gyro_ff;
      period_in = period_ff;
      if (csr_we) begin
         case (tcf_pkg::csr_index_type'(csr_index))
            tcf_pkg::CSR_ALPHA:  alpha_in  = csr_wdata[16:0];
            tcf_pkg::CSR_GYRO:   gyro_in   = csr_wdata;
            tcf_pkg::CSR_PERIOD: period_in = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff  <= tcf_pkg::ALPHA_RESET;
         gyro_ff   <= tcf_pkg::GYRO_RESET;
         period_ff <= tcf_pkg::PERIOD_RESET;
      end else begin
         alpha_ff  <= alpha_in;
         gyro_ff   <= gyro_in;
         period_ff <= period_in;
      end
   end

   // Front: accept the sample, compute accelerometer tilt and scaled rate.
   tcf_front #(
      .CORDIC_STAGES (CORDIC_STAGES),
      .FRAC_BITS     (FRAC_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .accel_y    ($signed(req_tdata[15:0])),
      .accel_z    ($signed(req_tdata[31:16])),
      .gyro_x     ($signed(req_tdata[47:32])),
      .gyro_gain  (gyro_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // Queue: hold finished front results until the back end is free.
   tcf_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Back: advance the kept angle and drive the result register.
   tcf_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .alpha      (alpha_ff),
      .period     (period_ff),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .tilt_angle (tilt_angle),
      .tilt_rate  (tilt_rate)
   );

   assign rsp_tdata = {4'b0, tilt_rate, tilt_angle};

endmodule

[dv/tb_top.sv]
// Self-checking bench for tilt_complementary_filter: streams IMU samples in, checks every
// filtered angle and rate against a cycle-free fixed-point predictor held in a scoreboard.
// Depends on tcf_pkg and the tilt_complementary_filter RTL.
`timescale 1ns / 1ps

module tb_top;

   localparam int     CORDIC_STAGES = 16;
   localparam int     FRAC_BITS     = 16;
   localparam int     ATAN_STEPS    = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;
   localparam longint SAT_HI = (((64'sd512 <<< FRAC_BITS) - 1) < 64'sd33554431) ?
                               ((64'sd512 <<< FRAC_BITS) - 1) : 64'sd33554431;
   localparam longint SAT_LO = (-(64'sd512 <<< FRAC_BITS) > -64'sd33554432) ?
                               -(64'sd512 <<< FRAC_BITS) : -64'sd33554432;
   localparam longint HALF_TURN = 64'sd180 <<< FRAC_BITS;

   // atan(2^-i) in Q24 degrees, one entry per micro-rotation
   localparam longint ATAN_Q24 [0:23] = '{
      754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
      15018523, 7509720, 3754917, 1877466, 938734, 469367,
      234684, 117342, 58671, 29335, 14668, 7334,
      3667, 1833, 917, 458, 229, 115
   };

   typedef struct packed {
      logic signed [tcf_pkg::OUT_W-1:0] angle;
      logic signed [tcf_pkg::OUT_W-1:0] rate;
   } tilt_result_type;

   // Scoreboard: own copy of the registers and the kept angle, plus the queue of
   // filter outputs still owed by the block.
   class tilt_scoreboard;
      logic [16:0]     alpha;
      logic [23:0]     gyro_gain;
      logic [15:0]     period;
      longint          angle_est;
      tilt_result_type owed_q[$];
      int              errors;
      int              checked;

      function new();
         alpha      = tcf_pkg::ALPHA_RESET;
         gyro_gain  = tcf_pkg::GYRO_RESET;
         period     = tcf_pkg::PERIOD_RESET;
         angle_est  = 0;
         errors     = 0;
         checked    = 0;
      endfunction

      // round to nearest, halves away from zero
      function longint round_shift(longint v, int s);
         longint half;
         half = 64'sd1 <<< (s - 1);
         if (v >= 0) begin
            return (v + half) >>> s;
         end
         return -(((-v) + half) >>> s);
      endfunction

      function longint clamp(longint v);
         if (v > SAT_HI) begin
            return SAT_HI;
         end
         if (v < SAT_LO) begin
            return SAT_LO;
         end
         return v;
      endfunction

      function void write_reg(tcf_pkg::csr_index_type idx, logic [23:0] value);
         case (idx)
            tcf_pkg::CSR_ALPHA:  alpha     = value[16:0];
            tcf_pkg::CSR_GYRO:   gyro_gain = value;
            tcf_pkg::CSR_PERIOD: period    = value[15:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return owed_q.size();
      endfunction

      function void note_sample(logic signed [15:0] ay, logic signed [15:0] az,
                                logic signed [15:0] gx);
         longint          x, y, t, dx, dy, acc, tilt_acc, rate, incr, mix, a, g, p;
         tilt_result_type res;
         // accelerometer tilt: CORDIC vectoring with a quarter-turn pre-rotation
         x = longint'(az);
         y = longint'(ay);
         if (x == 0 && y == 0) begin
            tilt_acc = 0;
         end else begin
            x = x * 256;
            y = y * 256;
            acc = 0;
            if (x < 0) begin
               if (y >= 0) begin
                  t = x; x = y; y = -t;
                  acc = 64'sd90 <<< 24;
               end else begin
                  t = x; x = -y; y = t;
                  acc = -(64'sd90 <<< 24);
               end
            end
            for (int i = 0; i < ATAN_STEPS; i++) begin
               dx = y >>> i;
               dy = x >>> i;
               if (y >= 0) begin
                  x = x + dx; y = y - dy; acc = acc + ATAN_Q24[i];
               end else begin
                  x = x - dx; y = y + dy; acc = acc - ATAN_Q24[i];
               end
            end
            tilt_acc = round_shift(acc, 24 - FRAC_BITS);
            // clamp any overshoot past the half turn
            if (tilt_acc > HALF_TURN) tilt_acc = HALF_TURN;
            if (tilt_acc < -HALF_TURN) tilt_acc = -HALF_TURN;
         end
         // alpha above one acts as one
         a = (alpha > tcf_pkg::ALPHA_ONE) ? 64'sd65536 : longint'(alpha);
         g = longint'(gyro_gain);
         p = longint'(period);
         t = longint'(gx);
         rate = clamp(round_shift(t * g, 24 - FRAC_BITS));
         incr = round_shift(rate * p, 16);
         mix  = a * (angle_est + incr) + (64'sd65536 - a) * tilt_acc;
         angle_est = clamp(round_shift(mix, 16));
         res.angle = angle_est[tcf_pkg::OUT_W-1:0];
         res.rate  = rate[tcf_pkg::OUT_W-1:0];
         owed_q.push_back(res);
      endfunction

      function void check_result(logic [55:0] data);
         tilt_result_type want;
         logic signed [tcf_pkg::OUT_W-1:0] got_angle, got_rate;
         got_angle = data[25:0];
         got_rate  = data[51:26];
         if (owed_q.size() == 0) begin
            $display("%0t unexpected result: angle %0d rate %0d", $time, got_angle, got_rate);
            errors++;
            return;
         end
         want = owed_q.pop_front();
         checked++;
         if (got_angle !== want.angle) begin
            $display("%0t tilt_angle mismatch: expected %0d, actual %0d",
                     $time, want.angle, got_angle);
            errors++;
         end
         if (got_rate !== want.rate) begin
            $display("%0t tilt_rate mismatch: expected %0d, actual %0d",
                     $time, want.rate, got_rate);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;   // accel_y[15:0], accel_z[31:16], gyro_x[47:32]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;   // tilt_angle[25:0], tilt_rate[51:26], zero pad
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [23:0] csr_wdata;

   tilt_scoreboard sb = new();
   bit             calm;       // suppress idling on both sides
   int             samples_sent;
   int             settings_used;

   tilt_complementary_filter #(
      .CORDIC_STAGES (CORDIC_STAGES),
      .FRAC_BITS     (FRAC_BITS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Offer one sample, idling first at random; leave tvalid high after the accept so
   // the next call can either hold it or drop it, never both in one step.
   task automatic send_sample(input logic [15:0] ay, input logic [15:0] az,
                              input logic [15:0] gx);
      while (!calm && $urandom_range(99) < 35) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {gx, az, ay};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_sample(ay, az, gx);
      samples_sent++;
      @(negedge clock);
   endtask

   // Write one register once the block has drained; hold the write for one cycle.
   task automatic write_csr(input tcf_pkg::csr_index_type idx, input logic [23:0] value);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      sb.write_reg(idx, value);
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_regs(input logic [23:0] alpha_v, input logic [23:0] gyro_v,
                           input logic [23:0] period_v);
      write_csr(tcf_pkg::CSR_ALPHA, alpha_v);
      write_csr(tcf_pkg::CSR_GYRO, gyro_v);
      write_csr(tcf_pkg::CSR_PERIOD, period_v);
      settings_used++;
   endtask

   // Receiver: stall at random on the falling edge, check on the rising edge.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready <= calm || ($urandom_range(99) >= 35);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result(rsp_tdata);
      end
   end

   // Hard limit on the whole run
   initial begin
      #5ms;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      logic [23:0] a_v, g_v, p_v;
      logic [15:0] ay, az, gx;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      csr_we        = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      calm          = 1'b0;
      samples_sent  = 0;
      settings_used = 1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: reset defaults, axis and quadrant corners of the tilt
      send_sample(16'sd0, 16'sd0, 16'sd0);            // both axes zero
      send_sample(16'sd0, -16'sd100, 16'sd0);         // negative Z, zero Y
      send_sample(16'sd0, 16'h8000, 16'sd1);
      send_sample(16'sd0, 16'sd32767, -16'sd1);
      send_sample(16'sd32767, 16'sd0, 16'sd100);
      send_sample(16'h8000, 16'sd0, -16'sd100);
      send_sample(16'sd32767, 16'sd32767, 16'sd32767);
      send_sample(16'h8000, 16'h8000, 16'h8000);
      send_sample(16'h8000, 16'sd32767, 16'sd0);
      send_sample(16'sd32767, 16'h8000, 16'sd0);
      send_sample(16'sd1, 16'h8000, 16'sd5);          // just short of +180
      send_sample(-16'sd1, 16'h8000, -16'sd5);        // just short of -180
      send_sample(16'sd100, -16'sd50, 16'sd200);
      send_sample(-16'sd100, -16'sd50, -16'sd200);

      // Largest scale and period, pure gyro path: drive rate and angle into saturation
      set_regs(24'd65536, 24'hFFFFFF, 24'd65535);
      repeat (3) send_sample(16'sd0, 16'sd1000, 16'sd32767);
      repeat (3) send_sample(16'sd0, 16'sd1000, 16'h8000);

      // Alpha above one (upper write bits set too), zero scale and period
      set_regs(24'hFFFFFF, 24'd0, 24'd0);
      send_sample(16'sd500, 16'sd500, 16'sd32767);
      send_sample(-16'sd500, 16'sd500, 16'h8000);
      // Pure accelerometer path, smallest nonzero scale and period
      set_regs(24'd0, 24'd1, 24'd1);
      send_sample(16'sd500, -16'sd500, 16'sd32767);
      send_sample(-16'sd500, -16'sd500, 16'h8000);

      // Random phases, each under a fresh register setting
      for (int ph = 0; ph < 8; ph++) begin
         if (ph == 0) begin
            set_regs(24'(tcf_pkg::ALPHA_RESET), tcf_pkg::GYRO_RESET,
                     24'(tcf_pkg::PERIOD_RESET));
         end else begin
            case ($urandom_range(4))
               0:       a_v = 24'd0;
               1:       a_v = 24'd65536;
               2:       a_v = {7'($urandom_range(127)), 17'd0} |
                              24'($urandom_range(65537, 131071));
               3:       a_v = 24'($urandom_range(65536));
               default: a_v = 24'($urandom_range(60000, 65536));
            endcase
            case ($urandom_range(4))
               0:       g_v = 24'd0;
               1:       g_v = 24'd1;
               2:       g_v = 24'hFFFFFF;
               3:       g_v = 24'($urandom_range(24'hFFFFFF));
               default: g_v = 24'($urandom_range(60000, 300000));
            endcase
            case ($urandom_range(4))
               0:       p_v = 24'd0;
               1:       p_v = 24'd1;
               2:       p_v = 24'd65535;
               3:       p_v = 24'($urandom_range(65535));
               default: p_v = 24'($urandom_range(100, 3000));
            endcase
            set_regs(a_v, g_v, p_v);
         end
         calm = (ph == 3);
         for (int n = 0; n < 50; n++) begin
            case ($urandom_range(9))
               0: begin
                  ay = 16'($urandom_range(127)) - 16'd64;
                  az = 16'($urandom_range(127)) - 16'd64;
               end
               1: begin
                  ay = $urandom_range(1) ? 16'd0 : 16'($urandom);
                  az = (ay == 0) ? 16'($urandom) : 16'd0;
               end
               default: begin
                  ay = 16'($urandom);
                  az = 16'($urandom);
               end
            endcase
            gx = ($urandom_range(3) == 0) ? 16'($urandom_range(63) - 32) : 16'($urandom);
            send_sample(ay, az, gx);
         end
         calm = 1'b0;
      end

      // Drain, then let the pipeline settle past its latency
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (40) @(negedge clock);

      $display("Run covered %0d samples under %0d register settings; %0d results checked.",
               samples_sent, settings_used, sb.checked);
      if (sb.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches found", sb.errors);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[sim.f]
src/tcf_pkg.sv
src/tcf_front.sv
src/tcf_fifo.sv
src/tcf_back.sv
src/tilt_complementary_filter.sv
dv/tb_top.sv
